@@ hdl/prbm_pkg.sv @@
`timescale 1ns / 1ps

package prbm_pkg;

   // Field widths
   localparam int RAW_W   = 32;
   localparam int PCM_W   = 16;
   localparam int PCM_LSB = 14;
   localparam int SQ_W    = 31;        // a square of a 16-bit magnitude fits here
   localparam int RAD_W   = 32;        // square root radicand
   localparam int ROOT_W  = 16;
   localparam int REM_W   = ROOT_W + 4;

   localparam logic [ROOT_W-1:0] RMS_FULL_SCALE = 16'h8000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_ROOT,
      ST_RESULT
   } state_type;

endpackage

@@ hdl/prbm_if.sv @@
`timescale 1ns / 1ps

interface prbm_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [prbm_pkg::RAW_W-1:0]  raw_sample;
   logic                               last_in_block;

   modport source (output valid, raw_sample, last_in_block, input ready);
   modport sink   (input valid, raw_sample, last_in_block, output ready);
endinterface

interface prbm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [prbm_pkg::PCM_W-1:0]  pcm_sample;
   logic                               level_valid;
   logic        [prbm_pkg::ROOT_W-1:0] rms_level;

   modport source (output valid, pcm_sample, level_valid, rms_level, input ready);
   modport sink   (input valid, pcm_sample, level_valid, rms_level, output ready);
endinterface

@@ hdl/prbm_isqrt.sv @@
`timescale 1ns / 1ps

// Floor square root, two radicand bits per cycle.
module prbm_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [prbm_pkg::RAD_W-1:0]    radicand,
   output logic                          done,
   output logic [prbm_pkg::ROOT_W-1:0]   root
);

   localparam int STEP_W = $clog2(prbm_pkg::ROOT_W);

   logic [prbm_pkg::RAD_W-1:0]  rad_ff, rad_in;
   logic [prbm_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [prbm_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   logic [prbm_pkg::REM_W-1:0]  shifted;
   logic [prbm_pkg::REM_W-1:0]  trial;
   logic                        fits;

   always_comb begin
      shifted = {rem_ff[prbm_pkg::REM_W-3:0], rad_ff[prbm_pkg::RAD_W-1 -: 2]};
      trial   = prbm_pkg::REM_W'({root_ff, 2'b01});
      fits    = shifted >= trial;

      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[prbm_pkg::RAD_W-3:0], 2'b00};
         rem_in  = fits ? shifted - trial : shifted;
         root_in = {root_ff[prbm_pkg::ROOT_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(prbm_pkg::ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ hdl/pcm_block_rms_meter.sv @@
`timescale 1ns / 1ps

// Block RMS meter for a 32-bit microphone stream. Every transfer on req_bus
// yields exactly one transfer on rsp_bus: the PCM sample (raw bits 29..14)
// and, when the sample closes a block (last_in_block set, or MAX_FRAMES
// samples reached), the floor RMS level of that block in Q15 with
// level_valid set; otherwise rms_level is 0. One sample is processed at a
// time: the square is built by a shift-add multiplier, one magnitude bit per
// cycle; an ordinary sample then moves to ST_RESULT, which loads its result
// into the output register once that register is free, and req_bus.ready is
// high again in the same cycle that the result appears there. A closing
// sample adds a restoring divide of the square sum by the sample count, one
// quotient bit per cycle, and a square root at two radicand bits per cycle
// before ST_RESULT. The result sits in an output register, so the next
// sample is taken while it waits; a second result stalls only if the first
// is still not taken.
module pcm_block_rms_meter #(
   parameter int MAX_FRAMES = 256
) (
   input  logic              clock,
   input  logic              reset,
   prbm_req_if.sink          req_bus,
   prbm_rsp_if.source        rsp_bus
);

   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int SUM_W  = prbm_pkg::SQ_W + $clog2(MAX_FRAMES);
   localparam int STEP_W = $clog2(SUM_W);
   localparam int PCM_W  = prbm_pkg::PCM_W;
   localparam int ROOT_W = prbm_pkg::ROOT_W;

   prbm_pkg::state_type state_ff, state_in;

   logic [PCM_W-1:0]  pcm_ff, pcm_in;
   logic [PCM_W-1:0]  mplier_ff, mplier_in;     // magnitude, shifted right
   logic [SUM_W-1:0]  mcand_ff, mcand_in;       // magnitude, shifted left
   logic [SUM_W-1:0]  sum_ff, sum_in;           // square sum, then quotient
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              close_ff, close_in;
   logic [ROOT_W-1:0] level_ff, level_in;

   logic              out_valid_ff, out_valid_in;
   logic [PCM_W-1:0]  out_pcm_ff, out_pcm_in;
   logic              out_lvl_ff, out_lvl_in;
   logic [ROOT_W-1:0] out_rms_ff, out_rms_in;

   logic [PCM_W-1:0]  pcm_raw;
   logic [PCM_W-1:0]  mag;
   logic [CNT_W-1:0]  count_next;
   logic [CNT_W:0]    div_trial;
   logic              div_fit;
   logic              out_free;

   logic                       sqrt_start;
   logic                       sqrt_done;
   logic [prbm_pkg::RAD_W-1:0] radicand;
   logic [ROOT_W-1:0]          root;

   // PCM conversion: arithmetic shift by 14 then wrap to 16 bits.
   assign pcm_raw    = req_bus.raw_sample[prbm_pkg::PCM_LSB +: PCM_W];
   assign mag        = pcm_raw[PCM_W-1] ? PCM_W'(~pcm_raw + PCM_W'(1)) : pcm_raw;
   assign count_next = count_ff + CNT_W'(1);

   // One restoring divide step.
   assign div_trial = {rem_ff, sum_ff[SUM_W-1]};
   assign div_fit   = div_trial >= {1'b0, count_ff};

   assign out_free = !out_valid_ff || rsp_bus.ready;

   // Mean fits 31 bits: it never exceeds the largest square.
   assign radicand = prbm_pkg::RAD_W'(sum_in[prbm_pkg::SQ_W-1:0]);

   always_comb begin
      state_in       = state_ff;
      pcm_in         = pcm_ff;
      mplier_in      = mplier_ff;
      mcand_in       = mcand_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      close_in       = close_ff;
      level_in       = level_ff;
      out_pcm_in     = out_pcm_ff;
      out_lvl_in     = out_lvl_ff;
      out_rms_in     = out_rms_ff;
      out_valid_in   = out_valid_ff && !rsp_bus.ready;
      sqrt_start     = 1'b0;
      req_bus.ready  = 1'b0;

      unique case (state_ff)
         prbm_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               pcm_in    = pcm_raw;
               mplier_in = mag;
               mcand_in  = SUM_W'(mag);
               count_in  = count_next;
               close_in  = req_bus.last_in_block || (count_next == CNT_W'(MAX_FRAMES));
               level_in  = '0;
               step_in   = '0;
               state_in  = prbm_pkg::ST_SQUARE;
            end
         end
         prbm_pkg::ST_SQUARE: begin
            if (mplier_ff[0]) begin
               sum_in = sum_ff + mcand_ff;
            end
            mplier_in = mplier_ff >> 1;
            mcand_in  = mcand_ff << 1;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(PCM_W - 1)) begin
               step_in  = '0;
               rem_in   = '0;
               state_in = close_ff ? prbm_pkg::ST_DIVIDE : prbm_pkg::ST_RESULT;
            end
         end
         prbm_pkg::ST_DIVIDE: begin
            rem_in  = div_fit ? CNT_W'(div_trial - {1'b0, count_ff}) : CNT_W'(div_trial);
            sum_in  = {sum_ff[SUM_W-2:0], div_fit};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               sqrt_start = 1'b1;
               state_in   = prbm_pkg::ST_ROOT;
            end
         end
         prbm_pkg::ST_ROOT: begin
            if (sqrt_done) begin
               level_in = root;
               sum_in   = '0;
               count_in = '0;
               state_in = prbm_pkg::ST_RESULT;
            end
         end
         prbm_pkg::ST_RESULT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_pcm_in   = pcm_ff;
               out_lvl_in   = close_ff;
               out_rms_in   = level_ff;
               state_in     = prbm_pkg::ST_IDLE;
            end
         end
         default: state_in = prbm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prbm_pkg::ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         step_ff      <= '0;
         close_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         close_ff     <= close_in;
         out_valid_ff <= out_valid_in;
      end
      pcm_ff     <= pcm_in;
      mplier_ff  <= mplier_in;
      mcand_ff   <= mcand_in;
      rem_ff     <= rem_in;
      level_ff   <= level_in;
      out_pcm_ff <= out_pcm_in;
      out_lvl_ff <= out_lvl_in;
      out_rms_ff <= out_rms_in;
   end

   prbm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (root)
   );

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.pcm_sample  = out_pcm_ff;
   assign rsp_bus.level_valid = out_lvl_ff;
   assign rsp_bus.rms_level   = out_rms_ff;

endmodule

@@ hdl/prbm_checker.sv @@
`timescale 1ns / 1ps

module prbm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [prbm_pkg::PCM_W-1:0]    rsp_pcm,
   input logic                          rsp_level_valid,
   input logic [prbm_pkg::ROOT_W-1:0]   rsp_rms
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_pcm) && $stable(rsp_level_valid) && $stable(rsp_rms))
      else $error("result changed while stalled");

   // No level without a closed block.
   a_no_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_level_valid |-> rsp_rms == '0)
      else $error("rms_level nonzero without level_valid");

   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rms <= prbm_pkg::RMS_FULL_SCALE)
      else $error("rms_level above full scale");

   // One sample at a time: the square takes many cycles.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample taken while squaring");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pcm_block_rms_meter prbm_checker u_prbm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_pcm         (rsp_bus.pcm_sample),
   .rsp_level_valid (rsp_bus.level_valid),
   .rsp_rms         (rsp_bus.rms_level)
);

@@ dv/tb_pcm_block_rms_meter.sv @@
`timescale 1ns / 1ps

module tb_pcm_block_rms_meter;

   localparam int MAX_FRAMES   = 256;
   localparam int SAMPLE_ITEMS = 1550;   // rough stimulus length, not a quota
   localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
   localparam int QUIET_LIMIT  = 5000;   // cycles with no transfer before giving up
   localparam int SETTLE_LIMIT = 120;    // wind-down wait after the last result

   logic clock;
   logic reset;

   prbm_req_if req_bus ();
   prbm_rsp_if rsp_bus ();

   pcm_block_rms_meter #(.MAX_FRAMES(MAX_FRAMES)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // ------------------------------------------------------------------
   // Level predictor and result store
   // ------------------------------------------------------------------
   // Tracks the running square sum and sample count of the open block and
   // queues one expected result per accepted sample.
   class rms_scoreboard;
      typedef struct {
         logic signed [prbm_pkg::PCM_W-1:0] pcm;
         logic                              closes;
         logic [prbm_pkg::ROOT_W-1:0]       level;
      } level_result_type;

      logic [63:0]      block_energy;
      int unsigned      block_samples;
      level_result_type expected_q[$];
      int               errors;

      function new();
         block_energy  = '0;
         block_samples = 0;
         errors        = 0;
      endfunction

      // floor square root, built one root bit at a time from the top
      function logic [prbm_pkg::ROOT_W-1:0] floor_root(logic [63:0] v);
         logic [63:0] root;
         logic [63:0] trial;
         root = '0;
         for (int b = 16; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
         end
         return root[prbm_pkg::ROOT_W-1:0];
      endfunction

      function void note_sample(logic [prbm_pkg::RAW_W-1:0] raw, logic last);
         level_result_type r;
         logic [prbm_pkg::PCM_W-1:0] bits;
         logic [16:0]                mag;
         bits = raw[prbm_pkg::PCM_LSB +: prbm_pkg::PCM_W];
         mag  = bits[prbm_pkg::PCM_W-1] ? (17'h10000 - {1'b0, bits}) : {1'b0, bits};
         block_energy  += 64'(mag) * 64'(mag);
         block_samples += 1;
         r.pcm    = bits;
         r.closes = 1'b0;
         r.level  = '0;
         // block closes on the flag or on the MAX_FRAMES-th sample
         if (last || block_samples >= MAX_FRAMES) begin
            r.closes      = 1'b1;
            r.level       = floor_root(block_energy / 64'(block_samples));
            block_energy  = '0;
            block_samples = 0;
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(logic signed [prbm_pkg::PCM_W-1:0] pcm, logic closes,
                                 logic [prbm_pkg::ROOT_W-1:0] level);
         level_result_type r;
         if (expected_q.size() == 0) begin
            $error("unexpected result: pcm_sample %0d level_valid %0b rms_level %0d",
                   pcm, closes, level);
            errors++;
            return;
         end
         r = expected_q.pop_front();
         if (pcm !== r.pcm) begin
            $error("pcm_sample: expected %0d, got %0d", r.pcm, pcm);
            errors++;
         end
         if (closes !== r.closes) begin
            $error("level_valid: expected %0b, got %0b", r.closes, closes);
            errors++;
         end
         if (level !== r.level) begin
            $error("rms_level: expected %0d, got %0d", r.level, level);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void check_drained();
         if (expected_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_q.size());
            errors += expected_q.size();
         end
      endfunction
   endclass

   rms_scoreboard levels = new();

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender state
   int items_sent;
   int burst_left;
   bit gapless;         // disables sender gaps during the back-pressure phase
   int holds_requested; // bumped by the stimulus to start a receiver hold-off

   // ------------------------------------------------------------------
   // Receiver: ready pattern with its own modes, plus the long hold-off
   // ------------------------------------------------------------------
   int stall_mode;
   int mode_left;
   int hold_left;
   int holds_served;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_mode    <= 0;
         mode_left     <= 0;
         hold_left     <= 0;
         holds_served  <= 0;
      end else begin
         // fields sampled here are pre-edge values, so order in the step is moot
         if (rsp_bus.valid && rsp_bus.ready)
            levels.check_result(rsp_bus.pcm_sample, rsp_bus.level_valid,
                                rsp_bus.rms_level);

         if (holds_served != holds_requested) begin
            holds_served  <= holds_requested;
            hold_left     <= HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode <= $urandom_range(0, 3);
               mode_left  <= $urandom_range(20, 200);
            end else begin
               mode_left <= mode_left - 1;
            end
            case (stall_mode)
               0: rsp_bus.ready <= 1'b1;                              // never stalls
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));          // coin flip
               2: rsp_bus.ready <= (mode_left[1:0] == 2'd0);          // one in four
               default: rsp_bus.ready <= ($urandom_range(0, 7) != 0); // rare stalls
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: counts cycles with no transfer on either channel
   // ------------------------------------------------------------------
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
         $display("tb_pcm_block_rms_meter failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sender tasks
   // ------------------------------------------------------------------
   // Offers one sample and returns at the edge where it transfers, with
   // valid left high so a following sample goes out back to back. Between
   // bursts, unless gapless is set, a random gap may drop valid.
   task automatic drive_sample(input logic [prbm_pkg::RAW_W-1:0] raw, input logic last);
      int gap;
      if (burst_left <= 0 && !gapless) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 24);
      end
      req_bus.valid         <= 1'b1;
      req_bus.raw_sample    <= raw;
      req_bus.last_in_block <= last;
      do @(posedge clock); while (!req_bus.ready);
      levels.note_sample(raw, last);
      items_sent++;
      burst_left--;
   endtask

   // Sender pause until every expected result is back.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (levels.pending() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   // Raw word built around a chosen PCM value; bits 31..30 and 13..0 are
   // random filler the block must drop.
   function automatic logic [prbm_pkg::RAW_W-1:0] random_raw(bit loud);
      logic [prbm_pkg::PCM_W-1:0] pcm;
      logic [1:0]                 top_bits;
      logic [13:0]                low_bits;
      top_bits = 2'($urandom);
      low_bits = 14'($urandom);
      if (loud) begin
         pcm = 16'h8000;                              // full-scale negative
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: pcm = 16'($urandom);
            4:          pcm = 16'($urandom_range(0, 64)) - 16'd32;
            5:          pcm = 16'h8000;
            6:          pcm = 16'h7FFF;
            7:          pcm = 16'h8001;
            8:          pcm = 16'h0000;
            default:    pcm = 16'($urandom_range(0, 255)) << $urandom_range(0, 8);
         endcase
      end
      return {top_bits, pcm, low_bits};
   endfunction

   // One block of len samples; flag_end sets last_in_block on the final one.
   task automatic send_block(input int len, input bit flag_end, input bit loud);
      for (int i = 0; i < len; i++)
         drive_sample(random_raw(loud), flag_end && (i == len - 1));
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int  pick;
      int  len;
      bit  loud;
      bit  pressure_done;

      items_sent      = 0;
      burst_left      = 0;
      gapless         = 1'b0;
      holds_requested = 0;
      pressure_done   = 1'b0;

      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.raw_sample    <= '0;
      req_bus.last_in_block <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: extremes and single-sample blocks ---
      drive_sample(32'h0000_0000, 1'b1);   // silence, level 0
      drive_sample(32'h2000_0000, 1'b1);   // -32768 alone: level is full scale
      drive_sample(32'h1FFF_C000, 1'b1);   // +32767 alone
      drive_sample(32'hFFFF_C000, 1'b1);   // -1 alone: level 1
      drive_sample(32'hFFFF_FFFF, 1'b1);   // all ones, low bits dropped
      drive_sample(32'h8000_0000, 1'b0);   // only bit 31 set: pcm 0, no level
      drive_sample(32'h7FFF_FFFF, 1'b0);   // bit 31 clear, pcm -1
      drive_sample(32'h4000_0000, 1'b1);   // bit 30 only: pcm 0
      drive_sample(32'h0000_3FFF, 1'b0);   // only the dropped low bits
      drive_sample(32'hDEAD_BEEF, 1'b0);
      drive_sample(32'h1234_5678, 1'b1);
      drive_sample(32'h2000_0000, 1'b0);   // two full-scale samples
      drive_sample(32'hE000_0000, 1'b1);
      drive_sample(32'h1FFF_C000, 1'b0);   // mixed-sign three-sample block
      drive_sample(32'h2000_4000, 1'b0);
      drive_sample(32'h0000_4000, 1'b1);
      drive_sample(32'h5555_5555, 1'b1);
      drive_sample(32'hAAAA_AAAA, 1'b1);
      wait_for_drain();

      // --- random blocks ---
      while (items_sent < SAMPLE_ITEMS) begin
         pick = $urandom_range(0, 99);
         loud = ($urandom_range(0, 9) == 0);
         if (pick < 4) begin
            // unflagged run: the block closes on its own at MAX_FRAMES
            send_block(MAX_FRAMES, 1'b0, loud);
         end else if (pick < 14) begin
            // noise: flags scattered at random
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
               drive_sample(random_raw(1'b0), ($urandom_range(0, 7) == 0));
         end else begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                              : $urandom_range(4, 40);
            send_block(len, 1'b1, loud);
         end

         // back-pressure: receiver holds off while samples keep coming,
         // then the sender pauses until the queue of results is empty
         if (!pressure_done && items_sent >= 500) begin
            pressure_done = 1'b1;
            holds_requested++;
            gapless = 1'b1;
            send_block(12, 1'b1, 1'b0);
            gapless = 1'b0;
            wait_for_drain();
         end else if ($urandom_range(0, 29) == 0) begin
            wait_for_drain();
         end
      end

      // --- wind down ---
      req_bus.valid <= 1'b0;
      while (levels.pending() != 0) @(posedge clock);
      repeat (SETTLE_LIMIT) @(posedge clock);
      levels.check_drained();
      if (levels.errors == 0)
         $display("tb_pcm_block_rms_meter passed");
      else
         $display("tb_pcm_block_rms_meter failed");
      $finish;
   end

endmodule
